// ----- design/polygon_point_inclusion_test_unit_defines.svh -----
// Assertion macros for the port-level checker.
`ifndef POLYGON_POINT_INCLUSION_TEST_UNIT_DEFINES_SVH
`define POLYGON_POINT_INCLUSION_TEST_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PPIT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ppit: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define PPIT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ppit: next-cycle check failed");

`endif

// ----- design/ppit_pkg.sv -----
// Package: sizes, request codes, coordinate helper and edge-unit structs.
package ppit_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int MAX_RINGS    = 16;
  localparam int COORD_BITS   = 32;

  localparam int COORD_W = 32;
  localparam int TAG_W   = 32;
  localparam int VERT_W  = 2 * COORD_W;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;

  localparam int VADDR_W = $clog2(MAX_VERTICES);
  localparam int VCNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int RADDR_W = (MAX_RINGS > 1) ? $clog2(MAX_RINGS) : 1;
  localparam int RCNT_W  = $clog2(MAX_RINGS + 1);

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic valid;
    logic last;
  } edge_ctl_t;

  typedef struct packed {
    logic valid;
    logic flip;
    logic last;
  } edge_res_t;

  // Sign-extend the low COORD_BITS bits of a coordinate field.
  function automatic coord_t coord_norm(input logic [COORD_W-1:0] raw);
    coord_t s;
    s = $signed(raw << (COORD_W - COORD_BITS));
    return s >>> (COORD_W - COORD_BITS);
  endfunction

endpackage

// ----- design/polygon_point_inclusion_test_unit.sv -----
// Top level: polygon ring store and point-in-polygon query sequencer.
//
// Command channel: an item is taken at a rising edge with start high and
// busy low. req_type selects clear, vertex load or point query; code 3 is
// ignored. Clear and load finish in the cycle of their transfer and never
// raise busy. A query raises busy while it walks the stored rings.
// Result channel: result_valid is high for exactly one cycle with
// result_tag, inside_res and store_overflow; the receiver cannot stall it.
// busy is already low in that cycle, so the next command may follow.
// With no closed ring a query answers in the cycle after its transfer;
// otherwise the vertex RAM read port streams one edge per cycle into the
// pipelined crossing test, and each ring adds a ring-end lookup, a
// priming read and a pipeline drain.
// Vertices of a ring that is still open are not walked.
// Reset (synchronous, active high) empties the store and clears the
// overflow flag; RAM contents are left as they are and are only read
// where written since the last clear, so no clearing pass is needed.
// Writes happen only while idle and read data is used only during a
// query, so the RAM ports never collide.
module polygon_point_inclusion_test_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   req_type,
  input  logic signed [ppit_pkg::COORD_W-1:0] coord_x,
  input  logic signed [ppit_pkg::COORD_W-1:0] coord_y,
  input  logic                         ring_close,
  input  logic [ppit_pkg::TAG_W-1:0]   point_tag,
  output logic                         result_valid,
  output logic [ppit_pkg::TAG_W-1:0]   result_tag,
  output logic                         inside_res,
  output logic                         store_overflow
);
  import ppit_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_RING, S_RANGE, S_WALK, S_DRAIN, S_DONE
  } state_t;

  state_t state;

  // store bookkeeping
  logic [VCNT_W-1:0] vertex_count;
  logic [RCNT_W-1:0] ring_count;
  logic [VCNT_W-1:0] open_start;   // start of the ring being loaded
  logic              ovf_flag;

  // query walk
  logic [RCNT_W-1:0] ring_idx;
  logic [VCNT_W-1:0] ring_first, ring_stop, vidx;
  logic              prime_pend, rd_v, rd_last;
  logic              odd, in_poly;
  coord_t            q_x, q_y, prev_x, prev_y;
  logic [TAG_W-1:0]  q_tag;

  // RAM ports
  logic               v_we, r_we;
  logic [VADDR_W-1:0] v_waddr, v_raddr;
  logic [VERT_W-1:0]  v_wdata, v_rdata;
  logic [RADDR_W-1:0] r_waddr, r_raddr;
  logic [VCNT_W-1:0]  r_wdata, r_rdata;

  logic              accept, is_load, ring_ok, vert_ok;
  logic [VCNT_W-1:0] ring_end, end_prev;
  logic              degenerate, ring_fin, ring_bit, ring_last, walk_last;
  coord_t            cur_x, cur_y;
  edge_ctl_t         ectl;
  edge_res_t         eres;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign is_load = accept && (req_type == REQ_LOAD);
  assign ring_ok = ring_count < RCNT_W'(MAX_RINGS);
  assign vert_ok = vertex_count < VCNT_W'(MAX_VERTICES);

  // vertex append, and ring close (also when the vertex itself is dropped)
  assign v_we    = is_load && ring_ok && vert_ok;
  assign v_waddr = vertex_count[VADDR_W-1:0];
  assign v_wdata = {coord_norm(coord_y), coord_norm(coord_x)};
  assign r_we    = is_load && ring_ok && ring_close && (vert_ok || vertex_count > open_start);
  assign r_waddr = ring_count[RADDR_W-1:0];
  assign r_wdata = vert_ok ? vertex_count + 1'b1 : vertex_count;

  assign r_raddr    = ring_idx[RADDR_W-1:0];
  assign ring_end   = r_rdata;
  assign end_prev   = ring_end - 1'b1;
  assign degenerate = ring_end <= ring_first;
  assign walk_last  = vidx == (ring_stop - 1'b1);
  assign ring_last  = RCNT_W'(ring_idx + 1'b1) == ring_count;

  always_comb begin
    if (state == S_RANGE) begin
      v_raddr = end_prev[VADDR_W-1:0];   // closing vertex of the ring primes j
    end else begin
      v_raddr = vidx[VADDR_W-1:0];
    end
  end

  assign cur_x      = v_rdata[COORD_W-1:0];
  assign cur_y      = v_rdata[VERT_W-1:COORD_W];
  assign ectl.valid = rd_v;
  assign ectl.last  = rd_last;

  // a ring finishes on its last edge result, or at once if it is empty
  assign ring_fin = (state == S_RANGE && degenerate) ||
                    (state == S_DRAIN && eres.valid && eres.last);
  assign ring_bit = (state == S_RANGE) ? 1'b0 : (odd ^ eres.flip);

  ppit_ram #(.WIDTH(VERT_W), .DEPTH(MAX_VERTICES)) u_vertex_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  ppit_ram #(.WIDTH(VCNT_W), .DEPTH(MAX_RINGS)) u_ring_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_waddr),
    .wdata (r_wdata),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  ppit_edge_unit u_edge (
    .clk (clk),
    .rst (rst),
    .ctl (ectl),
    .xi  (cur_x),
    .yi  (cur_y),
    .xj  (prev_x),
    .yj  (prev_y),
    .tx  (q_x),
    .ty  (q_y),
    .res (eres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      vertex_count <= '0;
      ring_count   <= '0;
      open_start   <= '0;
      ovf_flag     <= 1'b0;
      prime_pend   <= 1'b0;
      rd_v         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      rd_v         <= 1'b0;
      prime_pend   <= 1'b0;

      // previous vertex of the walk feeds the j side of the next edge
      if (prime_pend || rd_v) begin
        prev_x <= cur_x;
        prev_y <= cur_y;
      end
      if (eres.valid) begin
        odd <= odd ^ eres.flip;
      end
      // outer ring sets the answer, any hole that holds the point clears it
      if (ring_fin) begin
        if (ring_idx == '0) begin
          in_poly <= ring_bit;
        end else if (ring_bit) begin
          in_poly <= 1'b0;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (req_type)
              REQ_CLEAR: begin
                vertex_count <= '0;
                ring_count   <= '0;
                open_start   <= '0;
                ovf_flag     <= 1'b0;
              end
              REQ_LOAD: begin
                if (!ring_ok || !vert_ok) begin
                  ovf_flag <= 1'b1;
                end
                if (v_we) begin
                  vertex_count <= vertex_count + 1'b1;
                end
                if (r_we) begin
                  ring_count <= ring_count + 1'b1;
                  open_start <= r_wdata;
                end
              end
              REQ_QUERY: begin
                q_x   <= coord_norm(coord_x);
                q_y   <= coord_norm(coord_y);
                q_tag <= point_tag;
                if (ring_count == '0) begin
                  result_valid <= 1'b1;
                  result_tag   <= point_tag;
                  inside_res   <= 1'b0;
                end else begin
                  ring_idx   <= '0;
                  ring_first <= '0;
                  in_poly    <= 1'b0;
                  state      <= S_RING;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_RING: begin
          state <= S_RANGE;
        end
        S_RANGE: begin
          odd       <= 1'b0;
          ring_stop <= ring_end;
          vidx      <= ring_first;
          if (degenerate) begin
            if (ring_last) begin
              state <= S_DONE;
            end else begin
              ring_idx   <= ring_idx + 1'b1;
              ring_first <= ring_end;
              state      <= S_RING;
            end
          end else begin
            prime_pend <= 1'b1;
            state      <= S_WALK;
          end
        end
        S_WALK: begin
          rd_v    <= 1'b1;
          rd_last <= walk_last;
          vidx    <= vidx + 1'b1;
          if (walk_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (ring_fin) begin
            if (ring_last) begin
              state <= S_DONE;
            end else begin
              ring_idx   <= ring_idx + 1'b1;
              ring_first <= ring_stop;
              state      <= S_RING;
            end
          end
        end
        S_DONE: begin
          result_valid <= 1'b1;
          result_tag   <= q_tag;
          inside_res   <= in_poly;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign store_overflow = ovf_flag;

endmodule

// ----- design/ppit_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ppit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/ppit_edge_unit.sv -----
// Pipelined even-odd crossing test of one edge against the query point.
module ppit_edge_unit (
  input  logic                clk,
  input  logic                rst,
  input  ppit_pkg::edge_ctl_t ctl,
  input  ppit_pkg::coord_t    xi,
  input  ppit_pkg::coord_t    yi,
  input  ppit_pkg::coord_t    xj,
  input  ppit_pkg::coord_t    yj,
  input  ppit_pkg::coord_t    tx,
  input  ppit_pkg::coord_t    ty,
  output ppit_pkg::edge_res_t res
);
  import ppit_pkg::*;

  logic signed [DIFF_W-1:0] dy_t, dx_v, dx_t, dy_v;
  logic                     straddle, up;

  logic                     s1_valid, s1_last, s1_cross, s1_up;
  logic signed [DIFF_W-1:0] s1_dy_t, s1_dx_v, s1_dx_t, s1_dy_v;

  logic                     s2_valid, s2_last, s2_cross, s2_up;
  logic signed [PROD_W-1:0] s2_lhs, s2_rhs;

  assign dy_t     = {ty[COORD_W-1], ty} - {yi[COORD_W-1], yi};
  assign dx_v     = {xj[COORD_W-1], xj} - {xi[COORD_W-1], xi};
  assign dx_t     = {tx[COORD_W-1], tx} - {xi[COORD_W-1], xi};
  assign dy_v     = {yj[COORD_W-1], yj} - {yi[COORD_W-1], yi};
  assign straddle = (yi < ty && yj >= ty) || (yj < ty && yi >= ty);
  assign up       = yj > yi;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= ctl.valid;
      s2_valid <= s1_valid;
    end
    s1_last  <= ctl.last;
    s1_cross <= straddle;
    s1_up    <= up;
    s1_dy_t  <= dy_t;
    s1_dx_v  <= dx_v;
    s1_dx_t  <= dx_t;
    s1_dy_v  <= dy_v;
    // exact cross-multiplied form of the crossing-x comparison
    s2_last  <= s1_last;
    s2_cross <= s1_cross;
    s2_up    <= s1_up;
    s2_lhs   <= s1_dy_t * s1_dx_v;
    s2_rhs   <= s1_dx_t * s1_dy_v;
  end

  assign res.valid = s2_valid;
  assign res.last  = s2_last;
  assign res.flip  = s2_cross && (s2_up ? (s2_lhs < s2_rhs) : (s2_rhs < s2_lhs));

endmodule

// ----- design/ppit_checker.sv -----
// Port-level checker for the polygon inclusion unit, with its bind.
`include "polygon_point_inclusion_test_unit_defines.svh"

module ppit_props (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] req_type,
  input logic       result_valid,
  input logic       store_overflow
);
  import ppit_pkg::*;

  // a result is shown only once the walk is over
  `PPIT_ASSERT_IMP(a_res_idle, clk, rst, result_valid, !busy)
  // every result stems from a walk or a query just taken
  `PPIT_ASSERT_IMP(a_res_cause, clk, rst, result_valid, $past(busy || (start && req_type == REQ_QUERY)))
  // only a query transfer starts a walk
  `PPIT_ASSERT_IMP(a_busy_cause, clk, rst, $rose(busy), $past(start && req_type == REQ_QUERY))
  // overflow stays set until a clear transfer
  `PPIT_ASSERT_NXT(a_ovf_sticky, clk, rst, store_overflow && !(start && !busy && req_type == REQ_CLEAR), store_overflow)

endmodule

bind polygon_point_inclusion_test_unit ppit_props u_ppit_props (.*);

// ----- test/ppit_checker.sv -----
`timescale 1ns / 1ps
// Checker: predicts each query answer from the command transfers and compares the results.
module ppit_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  logic [1:0]                 req_type,
  input  ppit_pkg::coord_t           coord_x,
  input  ppit_pkg::coord_t           coord_y,
  input  logic                       ring_close,
  input  logic [ppit_pkg::TAG_W-1:0] point_tag,
  input  logic                       result_valid,
  input  logic [ppit_pkg::TAG_W-1:0] result_tag,
  input  logic                       inside_res,
  input  logic                       store_overflow,
  output int                         fail_count,
  output int                         pending
);
  import ppit_pkg::*;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             in_poly;
    logic             ovf;
  } answer_t;

  answer_t answer_q[$];
  int      errs = 0;
  int      n_waiting = 0;

  // Shadow polygon store
  logic [VERT_W-1:0]  vert_mem [MAX_VERTICES];
  logic [VCNT_W-1:0]  ring_end [MAX_RINGS];
  logic [VCNT_W-1:0]  n_vert;
  logic [RCNT_W-1:0]  n_ring;
  logic               ovf_flag;

  assign fail_count = errs;
  assign pending    = n_waiting;

  // Even-odd crossing parity over vertices [first, stop); exact 66-bit products.
  function automatic logic ring_odd(int first, int stop, coord_t tx, coord_t ty);
    logic signed [PROD_W-1:0] xi, yi, xj, yj, px, py, lhs, rhs;
    logic odd;
    logic left_of;
    int   j;
    odd = 1'b0;
    if (stop <= first || stop > MAX_VERTICES) return 1'b0;
    px = tx;
    py = ty;
    j = stop - 1;
    for (int i = first; i < stop; i++) begin
      xi = $signed(vert_mem[i][COORD_W-1:0]);
      yi = $signed(vert_mem[i][VERT_W-1:COORD_W]);
      xj = $signed(vert_mem[j][COORD_W-1:0]);
      yj = $signed(vert_mem[j][VERT_W-1:COORD_W]);
      if ((yi < py && yj >= py) || (yj < py && yi >= py)) begin
        lhs = (py - yi) * (xj - xi);
        rhs = (px - xi) * (yj - yi);
        left_of = (yj > yi) ? (lhs < rhs) : (rhs < lhs);
        if (left_of) odd = ~odd;
      end
      j = i;
    end
    return odd;
  endfunction

  function automatic void take_request(logic [1:0] req, coord_t x, coord_t y, logic close,
                                       logic [TAG_W-1:0] tag);
    logic [VCNT_W-1:0] open_start;
    answer_t           ans;
    case (req)
      REQ_CLEAR: begin
        n_vert   = '0;
        n_ring   = '0;
        ovf_flag = 1'b0;
      end
      REQ_LOAD: begin
        open_start = (n_ring == 0) ? '0 : ring_end[n_ring - 1'b1];
        if (n_ring >= MAX_RINGS) begin
          ovf_flag = 1'b1;
        end else if (n_vert >= MAX_VERTICES) begin
          // vertex dropped, but a close still ends a non-empty open ring
          ovf_flag = 1'b1;
          if (close && n_vert > open_start) begin
            ring_end[n_ring] = n_vert;
            n_ring = n_ring + 1'b1;
          end
        end else begin
          vert_mem[n_vert] = {y, x};
          n_vert = n_vert + 1'b1;
          if (close) begin
            ring_end[n_ring] = n_vert;
            n_ring = n_ring + 1'b1;
          end
        end
      end
      REQ_QUERY: begin
        ans.tag     = tag;
        ans.ovf     = ovf_flag;
        ans.in_poly = 1'b0;
        if (n_ring > 0) begin
          ans.in_poly = ring_odd(0, ring_end[0], x, y);
          for (int r = 1; ans.in_poly && r < n_ring; r++) begin
            if (ring_odd(ring_end[r - 1], ring_end[r], x, y)) ans.in_poly = 1'b0;
          end
        end
        answer_q = {answer_q, ans};
        n_waiting++;
      end
      default: ;
    endcase
  endfunction

  // Results first, then the command of the same edge: a query's answer is
  // never due at the edge of its own transfer.
  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      n_vert   = '0;
      n_ring   = '0;
      ovf_flag = 1'b0;
      answer_q.delete();
      n_waiting = 0;
    end else begin
      if (result_valid) begin
        if (answer_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected result, expected none, actual tag %h inside %b ovf %b",
                   $time, result_tag, inside_res, store_overflow);
        end else begin
          want = answer_q.pop_front();
          n_waiting--;
          if (result_tag !== want.tag) begin
            errs++;
            $display("%0t: result_tag mismatch, expected %h, actual %h",
                     $time, want.tag, result_tag);
          end
          if (inside_res !== want.in_poly) begin
            errs++;
            $display("%0t: inside_res mismatch (tag %h), expected %b, actual %b",
                     $time, want.tag, want.in_poly, inside_res);
          end
          if (store_overflow !== want.ovf) begin
            errs++;
            $display("%0t: store_overflow mismatch (tag %h), expected %b, actual %b",
                     $time, want.tag, want.ovf, store_overflow);
          end
        end
      end
      if (start && !busy) take_request(req_type, coord_norm(coord_x), coord_norm(coord_y),
                                       ring_close, point_tag);
    end
  end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench top: polygon load and query stimulus with idle gaps, plus the verdict.
module tb_top;
  import ppit_pkg::*;

  // Request code the block must ignore
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Q16.16 unit
  localparam int ONE = 65536;

  // The limit is several times the slowest run of every item at the
  // worst-case query latency.
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int DRAIN_CYCLES = 400;
  localparam int ITEM_TARGET  = 1700;
  localparam int MAX_GAP      = 20;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic [1:0]       req_type;
  logic [31:0]      coord_x;
  logic [31:0]      coord_y;
  logic             ring_close;
  logic [TAG_W-1:0] point_tag;
  logic             result_valid;
  logic [TAG_W-1:0] result_tag;
  logic             inside_res;
  logic             store_overflow;

  int fail_count;
  int pending;
  int cycles = 0;
  int sent = 0;     // accepted transfers that the block acts on
  int idle_pct = 0; // chance, in percent, that the sender idles in a cycle

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  polygon_point_inclusion_test_unit dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .req_type       (req_type),
    .coord_x        (coord_x),
    .coord_y        (coord_y),
    .ring_close     (ring_close),
    .point_tag      (point_tag),
    .result_valid   (result_valid),
    .result_tag     (result_tag),
    .inside_res     (inside_res),
    .store_overflow (store_overflow)
  );

  ppit_checker chk (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .req_type       (req_type),
    .coord_x        (coord_x),
    .coord_y        (coord_y),
    .ring_close     (ring_close),
    .point_tag      (point_tag),
    .result_valid   (result_valid),
    .result_tag     (result_tag),
    .inside_res     (inside_res),
    .store_overflow (store_overflow),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // One command transfer. Called and returns at a rising edge. An optional
  // gap drops start first; otherwise start stays high back to back, so it
  // never sees two nonblocking writes in one step. start is held while busy.
  task automatic push_cmd(logic [1:0] req, logic [31:0] x, logic [31:0] y, logic close,
                          logic [TAG_W-1:0] tag);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    req_type   <= req;
    coord_x    <= x;
    coord_y    <= y;
    ring_close <= close;
    point_tag  <= tag;
    do @(posedge clk); while (busy);
    if (req != REQ_UNUSED) sent++;
  endtask

  // Shorthands; unused fields of an item still get random bits.
  task automatic load_vertex(logic [31:0] x, logic [31:0] y, logic close);
    push_cmd(REQ_LOAD, x, y, close, $urandom());
  endtask

  task automatic query_point(logic [31:0] x, logic [31:0] y);
    push_cmd(REQ_QUERY, x, y, 1'($urandom_range(1)), $urandom());
  endtask

  task automatic clear_store();
    push_cmd(REQ_CLEAR, $urandom(), $urandom(), 1'($urandom_range(1)), $urandom());
  endtask

  // Grid coordinate around a center: quantized so that vertex and query
  // y values coincide often (edge endpoints exactly on the scan line).
  // Now and then an extreme value stands in.
  function automatic logic [31:0] grid_coord(logic [31:0] c, logic [31:0] step, int reach);
    int k;
    k = $urandom_range(0, 2 * reach) - reach;
    case ($urandom_range(39))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return c + step * k;
    endcase
  endfunction

  // Outer ring, holes (down to one or two vertices), maybe an open tail,
  // then queries inside and around the shape.
  task automatic shape_episode(logic [31:0] cx, logic [31:0] cy, logic [31:0] step);
    int n;
    int holes;
    int m;
    int q;
    n = $urandom_range(3, 8);
    for (int k = 0; k < n; k++)
      load_vertex(grid_coord(cx, step, 8), grid_coord(cy, step, 8), k == n - 1);
    holes = $urandom_range(0, 3);
    for (int h = 0; h < holes; h++) begin
      m = $urandom_range(1, 6);
      for (int k = 0; k < m; k++)
        load_vertex(grid_coord(cx, step, 4), grid_coord(cy, step, 4), k == m - 1);
    end
    if ($urandom_range(3) == 0) begin
      m = $urandom_range(1, 3);
      for (int k = 0; k < m; k++)
        load_vertex(grid_coord(cx, step, 8), grid_coord(cy, step, 8), 1'b0);
    end
    q = $urandom_range(3, 10);
    for (int k = 0; k < q; k++) begin
      if ($urandom_range(7) == 0) query_point($urandom(), $urandom());
      else query_point(grid_coord(cx, step, 12), grid_coord(cy, step, 12));
    end
  endtask

  // Rings up to and past the slot count: any loads past the last slot are dropped and the flag sticks.
  task automatic ring_flood_episode(logic [31:0] cx, logic [31:0] cy, logic [31:0] step);
    int rings;
    int m;
    rings = $urandom_range(15, 19);
    for (int r = 0; r < rings; r++) begin
      m = (r == 0) ? $urandom_range(3, 6) : $urandom_range(1, 4);
      for (int k = 0; k < m; k++)
        load_vertex(grid_coord(cx, step, 8), grid_coord(cy, step, 8), k == m - 1);
    end
    repeat ($urandom_range(3, 6)) query_point(grid_coord(cx, step, 12),
                                              grid_coord(cy, step, 12));
  endtask

  // Fill the vertex store and keep loading: dropped vertices, closes that
  // still end a non-empty open ring, then queries over a full store.
  task automatic store_fill_episode(logic [31:0] cx, logic [31:0] cy, logic [31:0] step);
    int total;
    total = MAX_VERTICES + $urandom_range(2, 10);
    for (int k = 0; k < total; k++) begin
      if (k < MAX_VERTICES)
        load_vertex(grid_coord(cx, step, 8), grid_coord(cy, step, 8),
                    $urandom_range(19) == 0 || k == 2);
      else
        load_vertex($urandom(), $urandom(), 1'($urandom_range(1)));
    end
    repeat ($urandom_range(3, 5)) query_point(grid_coord(cx, step, 12),
                                              grid_coord(cy, step, 12));
  endtask

  // Unstructured items, ignored code included
  task automatic noise_episode();
    repeat ($urandom_range(5, 15))
      push_cmd(2'($urandom_range(0, 3)), $urandom(), $urandom(), 1'($urandom_range(1)),
               $urandom());
  endtask

  task automatic random_phase(int upto, logic with_fill);
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] step;
    int          kind;
    if (with_fill) begin
      clear_store();
      store_fill_episode($urandom(), $urandom(), 32'd1 << $urandom_range(0, 27));
    end
    while (sent < upto) begin
      cx   = ($urandom_range(1) == 0) ? $urandom() : $urandom_range(0, 64) * ONE;
      cy   = ($urandom_range(1) == 0) ? $urandom() : $urandom_range(0, 64) * ONE;
      step = 32'd1 << $urandom_range(0, 27);
      kind = $urandom_range(99);
      if (kind < 6) begin
        clear_store();
        ring_flood_episode(cx, cy, step);
      end else if (kind < 18) begin
        noise_episode();
      end else begin
        // now and then build on top of whatever is already stored
        if ($urandom_range(5) != 0) clear_store();
        shape_episode(cx, cy, step);
      end
    end
  endtask

  initial begin
    rst        <= 1'b1;
    start      <= 1'b0;
    req_type   <= REQ_CLEAR;
    coord_x    <= '0;
    coord_y    <= '0;
    ring_close <= 1'b0;
    point_tag  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part, no gaps.
    // Query before any ring is closed -> outside.
    push_cmd(REQ_QUERY, 32'd0, 32'd0, 1'b0, 32'h0000_0000);
    push_cmd(REQ_UNUSED, $urandom(), $urandom(), 1'b1, $urandom());
    // Square of side 20 around the origin.
    load_vertex(-10 * ONE, -10 * ONE, 1'b0);
    load_vertex( 10 * ONE, -10 * ONE, 1'b0);
    load_vertex( 10 * ONE,  10 * ONE, 1'b0);
    load_vertex(-10 * ONE,  10 * ONE, 1'b1);
    push_cmd(REQ_QUERY, 32'd0, 32'd0, 1'b1, 32'hffff_ffff);
    query_point(20 * ONE, 0);
    query_point(0, 10 * ONE);
    // Triangular hole over the origin.
    load_vertex(-2 * ONE, -2 * ONE, 1'b0);
    load_vertex( 2 * ONE, -2 * ONE, 1'b0);
    load_vertex( 0,        3 * ONE, 1'b1);
    query_point(0, 0);
    query_point(5 * ONE, 5 * ONE);
    // Open ring, then two- and one-vertex rings.
    load_vertex(0, 0, 1'b0);
    query_point(5 * ONE, -5 * ONE);
    load_vertex(ONE, ONE, 1'b1);
    load_vertex(3 * ONE, 3 * ONE, 1'b1);
    query_point(ONE, ONE);
    // Clear drops everything.
    clear_store();
    query_point(0, 0);
    // Triangle spanning the full coordinate range.
    load_vertex(32'h8000_0000, 32'h8000_0000, 1'b0);
    load_vertex(32'h7fff_ffff, 32'h8000_0000, 1'b0);
    load_vertex(32'h0000_0000, 32'h7fff_ffff, 1'b1);
    query_point(0, 0);
    query_point(32'h7fff_ffff, 32'h7fff_ffff);
    query_point(32'h8000_0000, 32'h8000_0000);

    // Random part in three idle settings; the middle one opens with a full
    // store, the last one runs gap-free.
    idle_pct = 38;
    random_phase(600, 1'b0);
    idle_pct = 53;
    random_phase(1200, 1'b1);
    idle_pct = 0;
    random_phase(ITEM_TARGET, 1'b0);

    start <= 1'b0;
    @(posedge clk);
    // Wait out outstanding answers (the watchdog covers a hang), then a
    // full query latency for anything stray.
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ----- polygon_point_inclusion_test_unit.f -----
+incdir+design
design/ppit_pkg.sv
design/ppit_ram.sv
design/ppit_edge_unit.sv
design/polygon_point_inclusion_test_unit.sv
design/ppit_checker.sv
test/ppit_checker.sv
test/tb_top.sv
